>>> hw/rtl/psev_pkg.sv
// Shared types, constants and saturating arithmetic for the postfix stack evaluator.
package psev_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int STACK_DEPTH = 16;

  localparam logic [2:0] MODE_NUM = 3'd0;
  localparam logic [2:0] MODE_ADD = 3'd1;
  localparam logic [2:0] MODE_SUB = 3'd2;
  localparam logic [2:0] MODE_MUL = 3'd3;
  localparam logic [2:0] MODE_DIV = 3'd4;
  localparam logic [2:0] MODE_END = 3'd5;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_DIVZERO   = 3'd1;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
  localparam logic [2:0] ERR_FULL      = 3'd3;
  localparam logic [2:0] ERR_MALFORMED = 3'd4;

  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [2:0]                    mode;
    logic signed [VALUE_WIDTH-1:0] operand_value;
  } token_t;

  typedef struct packed {
    logic [2:0]                    status;
    logic signed [VALUE_WIDTH-1:0] top_value;
    logic                          expression_done;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_WB,
    ST_DONE
  } state_t;

  // Absolute value as an unsigned word; the most negative value maps onto itself.
  function automatic logic [VALUE_WIDTH-1:0] magnitude(input logic signed [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH-1:0] u;
    u = v;
    return v[VALUE_WIDTH-1] ? (~u + 1'b1) : u;
  endfunction

  // Signed result from sign and magnitude, clamped to the value range.
  function automatic logic signed [VALUE_WIDTH-1:0] sat_mag(input logic neg, input logic ovf,
                                                           input logic [VALUE_WIDTH-1:0] mag);
    logic big;
    big = ovf || (mag > VAL_MAX);
    if (neg) begin
      return big ? VAL_MIN : (~mag + 1'b1);
    end
    return big ? VAL_MAX : mag;
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] add_sat(input logic signed [VALUE_WIDTH-1:0] a,
                                                           input logic signed [VALUE_WIDTH-1:0] b);
    logic [VALUE_WIDTH:0] s;
    s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
    if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
      return s[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
    end
    return s[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] sub_sat(input logic signed [VALUE_WIDTH-1:0] a,
                                                           input logic signed [VALUE_WIDTH-1:0] b);
    logic [VALUE_WIDTH:0] s;
    s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
    if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
      return s[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
    end
    return s[VALUE_WIDTH-1:0];
  endfunction

endpackage

>>> hw/rtl/postfix_stack_evaluator_unit.sv
// Top level of the postfix stack evaluator: token control, stack memory and arithmetic.
//
// Usage: each word on the token channel is one postfix token (a number to push,
// add, subtract, multiply, divide or end), carried with valid and ready. Each
// accepted token produces exactly one word on the result channel, giving the
// sticky status and the top of the stack, or on an end token the final result.
// Tokens are handled one at a time. Pushes, errors, end tokens and unused modes go
// straight from acceptance to the result state; add and subtract go through execute
// and write-back, multiply also through the multiply state, divide through the divide
// state, where the divider makes one quotient bit per cycle. The result appears as the
// next token can be taken. The operand stack lives in a synchronous memory; the top
// entry is also held in a register, so an operator reads only the deeper operand.
// Reset empties the stack and clears the error; memory contents are left as
// they were and are never read before being written. A result waits in the
// output register while the receiver stalls; the next token is accepted
// meanwhile and finishes its work, then holds until the output register frees.
module postfix_stack_evaluator_unit #(
  parameter int STACK_DEPTH = psev_pkg::STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              token_valid,
  output logic              token_ready,
  input  psev_pkg::token_t  token,
  output logic              result_valid,
  input  logic              result_ready,
  output psev_pkg::result_t result
);

  localparam int W  = psev_pkg::VALUE_WIDTH;
  localparam int F  = psev_pkg::FRAC_BITS;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  psev_pkg::state_t state, state_next;

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_m2;
  logic [2:0]          sticky;
  logic                end_flag;
  logic [2:0]          end_status;
  logic signed [W-1:0] end_value;
  logic signed [W-1:0] top;
  logic [2:0]          mode_q;
  logic signed [W-1:0] res_val;
  logic [2*W-1:0]      prod;
  logic                prod_neg;

  logic                accept;
  logic                no_err;
  logic                is_op;
  logic                op_go;
  logic                load_result;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic signed [W-1:0] mem_wdata;
  logic                mem_re;
  logic signed [W-1:0] mem_rdata;

  logic                div_start;
  logic                div_done;
  logic signed [W-1:0] div_quotient;

  // A token is taken only while the block is idle.
  assign token_ready = (state == psev_pkg::ST_IDLE);
  assign accept   = token_valid && token_ready;
  assign no_err   = (sticky == psev_pkg::ERR_NONE);
  assign is_op    = token.mode inside {psev_pkg::MODE_ADD, psev_pkg::MODE_SUB,
                                       psev_pkg::MODE_MUL, psev_pkg::MODE_DIV};
  assign count_m2 = count - CW'(2);

  // An operator proceeds to the arithmetic only with two entries and, for a
  // divide, a nonzero right operand (the cached top of the stack).
  assign op_go = accept && is_op && no_err && (count >= CW'(2)) &&
                 !((token.mode == psev_pkg::MODE_DIV) && (top == '0));

  always_comb begin
    state_next = state;
    case (state)
      psev_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = op_go ? psev_pkg::ST_EXEC : psev_pkg::ST_DONE;
        end
      end
      psev_pkg::ST_EXEC: begin
        case (mode_q)
          psev_pkg::MODE_MUL: state_next = psev_pkg::ST_MUL;
          psev_pkg::MODE_DIV: state_next = psev_pkg::ST_DIV;
          default:            state_next = psev_pkg::ST_WB;
        endcase
      end
      psev_pkg::ST_MUL: state_next = psev_pkg::ST_WB;
      psev_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = psev_pkg::ST_WB;
        end
      end
      psev_pkg::ST_WB:  state_next = psev_pkg::ST_DONE;
      psev_pkg::ST_DONE: begin
        if (!result_valid || result_ready) begin
          state_next = psev_pkg::ST_IDLE;
        end
      end
      default: state_next = psev_pkg::ST_IDLE;
    endcase
  end

  // Memory ports and handshakes. Only one token is in flight, so a read and a
  // write to the same entry never overlap and no forwarding is needed.
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = count[AW-1:0];
    mem_wdata   = token.operand_value;
    mem_re      = 1'b0;
    div_start   = 1'b0;
    load_result = 1'b0;
    case (state)
      psev_pkg::ST_IDLE: begin
        mem_re      = op_go;
        mem_we      = accept && (token.mode == psev_pkg::MODE_NUM) && no_err &&
                      (count != CW'(STACK_DEPTH));
      end
      psev_pkg::ST_EXEC: begin
        div_start = (mode_q == psev_pkg::MODE_DIV);
      end
      psev_pkg::ST_WB: begin
        mem_we    = 1'b1;
        mem_waddr = count_m2[AW-1:0];
        mem_wdata = res_val;
      end
      psev_pkg::ST_DONE: begin
        load_result = !result_valid || result_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= psev_pkg::ST_IDLE;
      count        <= '0;
      sticky       <= psev_pkg::ERR_NONE;
      end_flag     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (accept) begin
        end_flag <= (token.mode == psev_pkg::MODE_END);
        if (token.mode == psev_pkg::MODE_END) begin
          count  <= '0;
          sticky <= psev_pkg::ERR_NONE;
        end else if (no_err && (token.mode == psev_pkg::MODE_NUM)) begin
          if (count == CW'(STACK_DEPTH)) begin
            sticky <= psev_pkg::ERR_FULL;
          end else begin
            count <= count + 1'b1;
          end
        end else if (no_err && is_op) begin
          if (count < CW'(2)) begin
            sticky <= psev_pkg::ERR_UNDERFLOW;
          end else if (!op_go) begin
            sticky <= psev_pkg::ERR_DIVZERO;
          end
        end
      end

      if (state == psev_pkg::ST_WB) begin
        count <= count - 1'b1;
      end

      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q     <= token.mode;
      end_status <= (no_err && (count != CW'(1))) ? psev_pkg::ERR_MALFORMED : sticky;
      end_value  <= (no_err && (count == CW'(1))) ? top : '0;
      if ((token.mode == psev_pkg::MODE_NUM) && no_err && (count != CW'(STACK_DEPTH))) begin
        top <= token.operand_value;
      end
    end

    if (state == psev_pkg::ST_EXEC) begin
      case (mode_q)
        psev_pkg::MODE_ADD: res_val <= psev_pkg::add_sat(mem_rdata, top);
        psev_pkg::MODE_SUB: res_val <= psev_pkg::sub_sat(mem_rdata, top);
        default: begin
        end
      endcase
      prod     <= {{W{1'b0}}, psev_pkg::magnitude(mem_rdata)} *
                  {{W{1'b0}}, psev_pkg::magnitude(top)};
      prod_neg <= mem_rdata[W-1] ^ top[W-1];
    end

    // The product keeps its fraction width after a shift; anything above one
    // word's worth of integer bits is overflow.
    if (state == psev_pkg::ST_MUL) begin
      res_val <= psev_pkg::sat_mag(prod_neg, |prod[2*W-1:W+F], prod[W+F-1:F]);
    end

    if ((state == psev_pkg::ST_DIV) && div_done) begin
      res_val <= div_quotient;
    end

    if (state == psev_pkg::ST_WB) begin
      top <= res_val;
    end

    if (load_result) begin
      if (end_flag) begin
        result.status          <= end_status;
        result.top_value       <= end_value;
        result.expression_done <= 1'b1;
      end else begin
        result.status          <= sticky;
        result.top_value       <= (count != '0) ? top : '0;
        result.expression_done <= 1'b0;
      end
    end
  end

  psev_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (count_m2[AW-1:0]),
    .rdata (mem_rdata)
  );

  psev_divider u_divider (
    .clk          (clk),
    .rst          (rst),
    .start        (div_start),
    .dividend_mag (psev_pkg::magnitude(mem_rdata)),
    .divisor_mag  (psev_pkg::magnitude(top)),
    .neg          (mem_rdata[W-1] ^ top[W-1]),
    .done         (div_done),
    .quotient     (div_quotient)
  );

endmodule

>>> hw/rtl/psev_stack_ram.sv
// Operand stack storage: one write port and one registered read port.
module psev_stack_ram #(
  parameter int DEPTH = psev_pkg::STACK_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [AW-1:0]                         waddr,
  input  logic signed [psev_pkg::VALUE_WIDTH-1:0] wdata,
  input  logic                                  re,
  input  logic [AW-1:0]                         raddr,
  output logic signed [psev_pkg::VALUE_WIDTH-1:0] rdata
);

  logic signed [psev_pkg::VALUE_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/psev_divider.sv
// Restoring divider for signed fixed-point values, one quotient bit per cycle.
module psev_divider (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic [psev_pkg::VALUE_WIDTH-1:0]        dividend_mag,
  input  logic [psev_pkg::VALUE_WIDTH-1:0]        divisor_mag,
  input  logic                                    neg,
  output logic                                    done,
  output logic signed [psev_pkg::VALUE_WIDTH-1:0] quotient
);

  localparam int W  = psev_pkg::VALUE_WIDTH;
  localparam int F  = psev_pkg::FRAC_BITS;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  shreg;
  logic [W-1:0]  quo;
  logic [W-1:0]  divisor;
  logic [CW-1:0] cnt;
  logic          ovf;
  logic          neg_q;
  logic [W:0]    trial;
  logic [W-1:0]  top_bits;

  // The dividend is the magnitude shifted up by the fraction width. Its top
  // fraction-width bits seed the remainder; if they already reach the divisor,
  // the quotient cannot fit in one word and saturates.
  assign top_bits = W'(dividend_mag >> (W - F));
  assign trial    = {rem, shreg[W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CW'(1));
      if (start) begin
        cnt <= CW'(W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= top_bits;
      shreg   <= dividend_mag << F;
      divisor <= divisor_mag;
      ovf     <= (top_bits >= divisor_mag);
      neg_q   <= neg;
      quo     <= '0;
    end else if (cnt != '0) begin
      shreg <= shreg << 1;
      if (trial >= {1'b0, divisor}) begin
        rem <= W'(trial - {1'b0, divisor});
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign quotient = psev_pkg::sat_mag(neg_q, ovf, quo);

endmodule

>>> verif/postfix_eval_checker.sv
// Checker for the postfix evaluator: predicts each result word and compares it as it leaves.
module postfix_eval_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              token_valid,
  input  logic              token_ready,
  input  psev_pkg::token_t  token,
  input  logic              result_valid,
  input  logic              result_ready,
  input  psev_pkg::result_t result,
  output int                mismatches,
  output int                outstanding,
  output int                tokens_seen,
  output int                ends_seen,
  output int                error_ends
);
  timeunit 1ns;
  timeprecision 1ps;

  // Private copy of the evaluator state.
  logic signed [psev_pkg::VALUE_WIDTH-1:0] model_stack [psev_pkg::STACK_DEPTH];
  int unsigned                             model_depth = 0;
  logic [2:0]                              model_error = psev_pkg::ERR_NONE;

  psev_pkg::result_t predicted_results [$];
  int      mismatch_total = 0;
  int      token_total = 0;
  int      end_total = 0;
  int      error_end_total = 0;

  function automatic logic signed [psev_pkg::VALUE_WIDTH-1:0] clamp_value(longint v);
    if (v > longint'(psev_pkg::VAL_MAX)) return psev_pkg::VAL_MAX;
    if (v < longint'(psev_pkg::VAL_MIN)) return psev_pkg::VAL_MIN;
    return v[psev_pkg::VALUE_WIDTH-1:0];
  endfunction

  // Product and quotient are formed on magnitudes, so both truncate towards zero.
  function automatic logic signed [psev_pkg::VALUE_WIDTH-1:0] apply_operator(
      logic [2:0] op, longint lhs, longint rhs);
    longint mag_l;
    longint mag_r;
    longint q;
    bit     neg;
    mag_l = (lhs < 0) ? -lhs : lhs;
    mag_r = (rhs < 0) ? -rhs : rhs;
    neg   = (lhs < 0) != (rhs < 0);
    case (op)
      psev_pkg::MODE_ADD: return clamp_value(lhs + rhs);
      psev_pkg::MODE_SUB: return clamp_value(lhs - rhs);
      psev_pkg::MODE_MUL: q = (mag_l * mag_r) >>> psev_pkg::FRAC_BITS;
      default:            q = (mag_l <<< psev_pkg::FRAC_BITS) / mag_r;
    endcase
    return clamp_value(neg ? -q : q);
  endfunction

  function automatic psev_pkg::result_t evaluate_token(psev_pkg::token_t t);
    psev_pkg::result_t r;
    r.expression_done = 1'b0;
    if (t.mode == psev_pkg::MODE_END) begin
      r.status    = model_error;
      r.top_value = '0;
      if (r.status == psev_pkg::ERR_NONE && model_depth != 1) r.status = psev_pkg::ERR_MALFORMED;
      if (r.status == psev_pkg::ERR_NONE) r.top_value = model_stack[0];
      r.expression_done = 1'b1;
      model_depth = 0;
      model_error = psev_pkg::ERR_NONE;
      return r;
    end
    // While an error is held, only the end token has any effect.
    if (model_error == psev_pkg::ERR_NONE) begin
      if (t.mode == psev_pkg::MODE_NUM) begin
        if (model_depth >= psev_pkg::STACK_DEPTH) begin
          model_error = psev_pkg::ERR_FULL;
        end else begin
          model_stack[model_depth] = t.operand_value;
          model_depth++;
        end
      end else if (t.mode inside {[psev_pkg::MODE_ADD:psev_pkg::MODE_DIV]}) begin
        if (model_depth < 2) begin
          model_error = psev_pkg::ERR_UNDERFLOW;
        end else if (t.mode == psev_pkg::MODE_DIV && model_stack[model_depth-1] == 0) begin
          model_error = psev_pkg::ERR_DIVZERO;
        end else begin
          model_stack[model_depth-2] = apply_operator(t.mode, model_stack[model_depth-2],
                                                      model_stack[model_depth-1]);
          model_depth--;
        end
      end
    end
    r.status    = model_error;
    r.top_value = (model_depth > 0) ? model_stack[model_depth-1] : '0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_total++;
  endtask

  always @(posedge clk) begin
    psev_pkg::result_t want;
    if (rst) begin
      model_depth = 0;
      model_error = psev_pkg::ERR_NONE;
      predicted_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result word with nothing predicted", result.top_value, 0);
        end else begin
          want = predicted_results.pop_front();
          if (result.status !== want.status)
            report_mismatch("status", result.status, want.status);
          if (result.top_value !== want.top_value)
            report_mismatch("top_value", result.top_value, want.top_value);
          if (result.expression_done !== want.expression_done)
            report_mismatch("expression_done", result.expression_done, want.expression_done);
        end
      end
      if (token_valid && token_ready) begin
        want = evaluate_token(token);
        predicted_results.push_back(want);
        token_total++;
        if (want.expression_done) begin
          end_total++;
          if (want.status != psev_pkg::ERR_NONE) error_end_total++;
        end
      end
    end
    mismatches  <= mismatch_total;
    outstanding <= predicted_results.size();
    tokens_seen <= token_total;
    ends_seen   <= end_total;
    error_ends  <= error_end_total;
  end

endmodule

>>> verif/testbench.sv
// Top of the postfix evaluator testbench: clock, reset, token stimulus and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // The token field is three bits wide, so two codes are left over. The block must
  // treat them as no-operations that still produce a result word.
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  localparam logic signed [psev_pkg::VALUE_WIDTH-1:0] FX_ONE = 32'sh0001_0000;

  // Every input of the block starts at a known value.
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              token_valid = 1'b0;
  logic              token_ready;
  psev_pkg::token_t  token = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  psev_pkg::result_t result;

  int mismatches;
  int outstanding;
  int tokens_seen;
  int ends_seen;
  int error_ends;

  // Chance, in percent, that the sender holds back a word or the receiver stalls
  // in a given cycle. The three phases of the run change these.
  int src_idle_pct  = 22;
  int sink_idle_pct = 63;
  int words_sent    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  postfix_stack_evaluator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token        (token),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  postfix_eval_checker checker_inst (
    .clk          (clk),
    .rst          (rst),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token        (token),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .tokens_seen  (tokens_seen),
    .ends_seen    (ends_seen),
    .error_ends   (error_ends)
  );

  // The receiver draws a fresh ready every cycle, so its stalls land on every
  // stage of the block's work, including the long divide.
  always @(posedge clk) begin
    result_ready <= !rst && ($urandom_range(99) >= sink_idle_pct);
  end

  // Offers one token word and returns at the edge where it is taken. Valid is
  // lowered only while the sender idles, so back-to-back words keep it high and
  // it is never lowered and raised in the same step.
  task automatic send_word(logic [2:0] mode, logic signed [psev_pkg::VALUE_WIDTH-1:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      token_valid <= 1'b0;
      @(posedge clk);
    end
    token_valid         <= 1'b1;
    token.mode          <= mode;
    token.operand_value <= value;
    @(posedge clk);
    while (!token_ready) @(posedge clk);
    words_sent++;
  endtask

  // Operands are weighted towards small Q16.16 numbers, so that sums, products
  // and quotients mostly stay in range, with the extremes and raw random words
  // mixed in to drive saturation and exercise every bit.
  function automatic logic signed [psev_pkg::VALUE_WIDTH-1:0] random_value();
    logic signed [psev_pkg::VALUE_WIDTH-1:0] v;
    int                                      whole;
    v = $urandom;
    case ($urandom_range(11))
      0: v = psev_pkg::VAL_MAX;
      1: v = psev_pkg::VAL_MIN;
      2, 3: v = '0;
      4: v = v >>> $urandom_range(8, 30);
      5, 6: begin
        whole = $urandom_range(40) - 20;
        v = whole <<< psev_pkg::FRAC_BITS;
      end
      7, 8: v = v >>> 11;
      9: v = $urandom_range(1) ? FX_ONE : -FX_ONE;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] random_operator();
    case ($urandom_range(3))
      0: return psev_pkg::MODE_ADD;
      1: return psev_pkg::MODE_SUB;
      2: return psev_pkg::MODE_MUL;
      default: return psev_pkg::MODE_DIV;
    endcase
  endfunction

  // A valid postfix expression with random content. Numbers and operators are
  // interleaved at random while keeping at least two entries under each
  // operator, and the expression is folded down to a single entry before its end.
  task automatic well_formed_expression();
    int operands;
    int pushed;
    int depth;
    operands = ($urandom_range(9) == 0) ? $urandom_range(10, psev_pkg::STACK_DEPTH)
                                        : $urandom_range(1, 6);
    pushed   = 0;
    depth    = 0;
    while (pushed < operands || depth > 1) begin
      if (pushed < operands && (depth < 2 || $urandom_range(2) != 0)) begin
        send_word(psev_pkg::MODE_NUM, random_value());
        pushed++;
        depth++;
      end else begin
        send_word(random_operator(), $urandom);
        depth--;
      end
    end
    send_word(psev_pkg::MODE_END, $urandom);
  endtask

  // Fills the stack to exactly its depth and folds it back, or pushes past the
  // top to raise the full-stack error and then keeps going so that the sticky
  // error has tokens to ignore.
  task automatic stack_flood();
    int pushes;
    pushes = psev_pkg::STACK_DEPTH + $urandom_range(0, 2);
    for (int i = 0; i < pushes; i++) send_word(psev_pkg::MODE_NUM, random_value());
    if (pushes == psev_pkg::STACK_DEPTH) begin
      for (int i = 1; i < psev_pkg::STACK_DEPTH; i++) send_word(random_operator(), $urandom);
    end else if ($urandom_range(1)) begin
      send_word(random_operator(), $urandom);
    end
    send_word(psev_pkg::MODE_END, $urandom);
  endtask

  // Arbitrary token words, spare codes included; half the time no end token
  // follows, so the junk runs on into the next expression.
  task automatic noise_run();
    int count;
    count = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) send_word(3'($urandom), random_value());
    if ($urandom_range(1)) send_word(psev_pkg::MODE_END, $urandom);
  endtask

  task automatic run_random(int count);
    int stop;
    stop = words_sent + count;
    while (words_sent < stop) begin
      case ($urandom_range(9))
        0: stack_flood();
        1, 2: noise_run();
        default: well_formed_expression();
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed opening. Sums and differences that saturate at both ends, and a
    // product of the most negative value with minus one, which must clamp high.
    send_word(psev_pkg::MODE_NUM, psev_pkg::VAL_MAX);
    send_word(psev_pkg::MODE_NUM, 32'sd1);
    send_word(psev_pkg::MODE_ADD, '0);
    send_word(psev_pkg::MODE_END, '0);
    send_word(psev_pkg::MODE_NUM, psev_pkg::VAL_MIN);
    send_word(psev_pkg::MODE_NUM, 32'sd1);
    send_word(psev_pkg::MODE_SUB, '0);
    send_word(psev_pkg::MODE_NUM, -FX_ONE);
    send_word(psev_pkg::MODE_MUL, '0);
    send_word(psev_pkg::MODE_END, '0);
    // Division by zero; the number that follows must be ignored while the error holds.
    send_word(psev_pkg::MODE_NUM, 32'sh0003_0000);
    send_word(psev_pkg::MODE_NUM, '0);
    send_word(psev_pkg::MODE_DIV, '1);
    send_word(psev_pkg::MODE_NUM, 32'sd5);
    send_word(psev_pkg::MODE_END, '1);
    // An operator on an empty stack, then an end with nothing on the stack.
    send_word(psev_pkg::MODE_ADD, '0);
    send_word(psev_pkg::MODE_END, '0);
    send_word(psev_pkg::MODE_END, '0);
    // A quotient with a negative dividend (minus 7.5 by 2.0 gives minus 3.75),
    // with both spare codes in between to show they leave the stack alone.
    send_word(psev_pkg::MODE_NUM, 32'shFFF8_8000);
    send_word(psev_pkg::MODE_NUM, 32'sh0002_0000);
    send_word(psev_pkg::MODE_DIV, '0);
    send_word(MODE_SPARE_A, '1);
    send_word(MODE_SPARE_B, '0);
    send_word(psev_pkg::MODE_END, '0);

    // Random part in three handshake regimes: a slow receiver, then a slow
    // sender, then both at full rate.
    run_random(600);
    src_idle_pct  = 63;
    sink_idle_pct = 22;
    run_random(600);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(600);

    token_valid <= 1'b0;
    // Wait for the last result word, then allow for a full divide before judging.
    do @(posedge clk); while (outstanding != 0);
    repeat (40) @(posedge clk);

    $display("Run covered %0d token words in three idling regimes; %0d expressions ended,",
             tokens_seen, ends_seen);
    $display("%0d of them with an error status, including the full-stack and spare-code cases.",
             error_ends);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Several times the slowest correct run, even with every token a divide.
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
